[rtl/core/tspm_pkg.sv]
package tspm_pkg;

    localparam int PROBE_SLOTS_DEF     = 64;
    localparam int MAX_SACK_BLOCKS_DEF = 3;

    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_DONE   = 2'd1;
    localparam logic [1:0] CMD_OPTION = 2'd2;

    localparam logic [7:0] OPT_EOL   = 8'd0;
    localparam logic [7:0] OPT_NOP   = 8'd1;
    localparam logic [7:0] OPT_SACK  = 8'd5;
    localparam logic [7:0] OPT_HEAD  = 8'd2;
    localparam logic [7:0] BLOCK_BYTES   = 8'd8;
    localparam logic [7:0] MAX_SACK_BODY = 8'd24;

    localparam logic [2:0] ST_MATCH         = 3'd0;
    localparam logic [2:0] ST_NO_FREE       = 3'd1;
    localparam logic [2:0] ST_NO_SACK       = 3'd2;
    localparam logic [2:0] ST_ZERO_INTERVAL = 3'd3;
    localparam logic [2:0] ST_MALFORMED     = 3'd4;

    typedef enum logic [2:0] {
        PH_KIND, PH_LEN_OTHER, PH_LEN_SACK, PH_SKIP, PH_SACK_BODY, PH_ENDED
    } t_phase;

endpackage

[rtl/core/tcp_sack_option_probe_match_top.sv]
// SACK option probe matcher.
// Command channel: i_start with i_command/i_slot/i_seq_value/i_option_byte/i_last;
// a beat is taken when i_start is high and o_busy is low.
// Record (0) and done (1) commands, and option bytes without i_last, give no
// result; record/done/option beats may follow back to back.
// An option byte with i_last starts the verdict. If the options are malformed
// or the interval sum is zero the result is registered and shows in the cycle after.
// Otherwise the probe table is scanned in slot order, one slot per cycle through the
// sequence memory (registered read), until a matching slot that is neither done
// nor final, or the last slot; o_busy is high until the result appears.
// The result shows for one cycle with o_valid high; the receiver cannot stall.
// Reset clears the valid/done/final/reply marks and the parser state; the
// sequence memory itself is not cleared, entries are used only for valid slots.
module tcp_sack_option_probe_match_top #(
    parameter int PROBE_SLOTS     = tspm_pkg::PROBE_SLOTS_DEF,
    parameter int MAX_SACK_BLOCKS = tspm_pkg::MAX_SACK_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_command,
    input  logic [5:0]  i_slot,
    input  logic [31:0] i_seq_value,
    input  logic [7:0]  i_option_byte,
    input  logic        i_last,
    output logic        o_busy,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [5:0]  o_probe_slot,
    output logic [1:0]  o_block_count
);
    import tspm_pkg::*;

    localparam int SW = (PROBE_SLOTS > 1) ? $clog2(PROBE_SLOTS) : 1;
    localparam int CW = $clog2(PROBE_SLOTS + 1);
    localparam int BW = $clog2(MAX_SACK_BLOCKS + 1);
    localparam int NE = 2 * MAX_SACK_BLOCKS;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CHECK} t_state;

    logic [31:0] r_mem [PROBE_SLOTS];
    logic [31:0] r_rd;

    logic [PROBE_SLOTS-1:0] r_valid, r_done, r_final, r_reply;

    t_state      r_state;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_left, n_left;
    logic [31:0] r_edge [NE];
    logic [31:0] n_edge [NE];
    logic [BW-1:0] r_blocks, n_blocks;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_sum, n_sum;
    logic        r_sack, n_sack;
    logic        r_mal, n_mal;
    logic [CW-1:0] r_idx;
    logic [SW-1:0] r_cidx;
    logic        r_ovalid;
    logic [2:0]  r_status;
    logic [5:0]  r_pslot;
    logic [1:0]  r_bcount;

    wire accept   = i_start && (r_state == S_IDLE);
    wire slot_ok  = ({26'd0, i_slot} < 32'(PROBE_SLOTS));
    wire [SW-1:0] wslot = SW'(i_slot);
    wire do_rec   = accept && i_command == CMD_RECORD && slot_ok;
    wire do_done  = accept && i_command == CMD_DONE && slot_ok;
    wire do_opt   = accept && i_command == CMD_OPTION;

    // parser next state
    logic [7:0] body, rem;
    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_edge   = r_edge;
        n_blocks = r_blocks;
        n_acc    = r_acc;
        n_sum    = r_sum;
        n_sack   = r_sack;
        n_mal    = r_mal;
        body     = i_option_byte - OPT_HEAD;
        rem      = r_left - 8'd1;
        case (r_phase)
            PH_KIND: begin
                if (i_option_byte == OPT_EOL) n_phase = PH_ENDED;
                else if (i_option_byte == OPT_NOP) n_phase = PH_KIND;
                else if (i_option_byte == OPT_SACK) n_phase = PH_LEN_SACK;
                else n_phase = PH_LEN_OTHER;
            end
            PH_LEN_OTHER: begin
                if (i_option_byte < OPT_HEAD) begin
                    n_phase = PH_ENDED;
                end else begin
                    n_left  = body;
                    n_phase = (body != 8'd0) ? PH_SKIP : PH_KIND;
                end
            end
            PH_LEN_SACK: begin
                if (i_option_byte < OPT_HEAD || body[2:0] != 3'd0 || body > MAX_SACK_BODY
                    || (32'(r_blocks) + 32'(body[4:3]) > 32'(MAX_SACK_BLOCKS))) begin
                    n_mal   = 1'b1;
                    n_phase = PH_ENDED;
                end else begin
                    n_sack  = 1'b1;
                    n_left  = body;
                    n_acc   = '0;
                    n_phase = (body != 8'd0) ? PH_SACK_BODY : PH_KIND;
                end
            end
            PH_SKIP: begin
                n_left = rem;
                if (rem == 8'd0) n_phase = PH_KIND;
            end
            PH_SACK_BODY: begin
                n_acc  = {r_acc[23:0], i_option_byte};
                n_left = rem;
                if (32'(r_blocks) < 32'(MAX_SACK_BLOCKS)) begin
                    for (int k = 0; k < MAX_SACK_BLOCKS; k++) begin
                        if (32'(r_blocks) == k) begin
                            if (rem[2:0] == 3'd4) begin
                                n_edge[2*k] = n_acc;
                            end else if (rem[2:0] == 3'd0) begin
                                n_edge[2*k+1] = n_acc;
                                n_sum    = r_sum + (n_acc - r_edge[2*k]);
                                n_blocks = r_blocks + BW'(1);
                            end
                        end
                    end
                end
                if (rem == 8'd0) n_phase = PH_KIND;
            end
            default: n_phase = PH_ENDED;
        endcase
    end

    // hit test for the slot being checked
    logic hit;
    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < MAX_SACK_BLOCKS; k++) begin
            if (32'(r_blocks) > k && r_rd >= r_edge[2*k] && r_rd < r_edge[2*k+1])
                hit = 1'b1;
        end
    end
    wire cand = r_valid[r_cidx] && r_rd != 32'd0 && hit;

    // sequence memory: write on record, read at scan index
    always_ff @(posedge i_clk) begin
        if (do_rec) r_mem[wslot] <= i_seq_value;
        r_rd <= r_mem[SW'(r_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_done   <= '0;
            r_final  <= '0;
            r_reply  <= '0;
            r_phase  <= PH_KIND;
            r_left   <= '0;
            r_blocks <= '0;
            r_acc    <= '0;
            r_sum    <= '0;
            r_sack   <= 1'b0;
            r_mal    <= 1'b0;
            for (int k = 0; k < NE; k++) r_edge[k] <= '0;
            r_idx    <= '0;
            r_cidx   <= '0;
            r_ovalid <= 1'b0;
            r_status <= ST_NO_FREE;
            r_pslot  <= '0;
            r_bcount <= '0;
        end else begin
            r_ovalid <= 1'b0;
            if (do_rec) begin
                r_valid[wslot] <= 1'b1;
                r_done[wslot]  <= 1'b0;
                r_final[wslot] <= 1'b0;
                r_reply[wslot] <= 1'b0;
            end
            if (do_done) r_done[wslot] <= 1'b1;
            case (r_state)
                S_IDLE: begin
                    if (do_opt) begin
                        r_phase  <= n_phase;
                        r_left   <= n_left;
                        r_edge   <= n_edge;
                        r_blocks <= n_blocks;
                        r_acc    <= n_acc;
                        r_sum    <= n_sum;
                        r_sack   <= n_sack;
                        r_mal    <= n_mal;
                        if (i_last) begin
                            r_bcount <= 2'(n_blocks);
                            r_pslot  <= '0;
                            if (n_mal || n_sum == 32'd0) begin
                                r_ovalid <= 1'b1;
                                r_status <= n_mal ? ST_MALFORMED :
                                            (n_sack ? ST_ZERO_INTERVAL : ST_NO_SACK);
                                r_phase  <= PH_KIND;
                                r_left   <= '0;
                                r_blocks <= '0;
                                r_acc    <= '0;
                                r_sum    <= '0;
                                r_sack   <= 1'b0;
                                r_mal    <= 1'b0;
                                for (int k = 0; k < NE; k++) r_edge[k] <= '0;
                            end else begin
                                r_idx   <= '0;
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    // read of slot r_idx issued; compare next cycle
                    r_cidx  <= SW'(r_idx);
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    logic fin;
                    fin = 1'b0;
                    if (cand) begin
                        r_reply[r_cidx] <= 1'b1;
                        if (!r_done[r_cidx] && !r_final[r_cidx]) begin
                            r_final[r_cidx] <= 1'b1;
                            r_status <= ST_MATCH;
                            r_pslot  <= 6'(r_cidx);
                            fin = 1'b1;
                        end
                    end
                    if (!fin && 32'(r_idx) >= 32'(PROBE_SLOTS)) begin
                        r_status <= ST_NO_FREE;
                        fin = 1'b1;
                    end
                    if (fin) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                        r_phase  <= PH_KIND;
                        r_left   <= '0;
                        r_blocks <= '0;
                        r_acc    <= '0;
                        r_sum    <= '0;
                        r_sack   <= 1'b0;
                        r_mal    <= 1'b0;
                        for (int k = 0; k < NE; k++) r_edge[k] <= '0;
                    end else begin
                        r_cidx <= SW'(r_idx);
                        r_idx  <= r_idx + CW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_probe_slot  = r_pslot;
    assign o_block_count = r_bcount;

endmodule
